@@ rtl/core/dda_pkg.sv @@
// Shared constants and types of the DDA line rasterizer.
// Used by dda_divider and dda_line_rasterizer; depends on nothing else.
package dda_pkg;

    localparam int COORD_BITS = 10;
    localparam int FRAC_BITS = 16;
    localparam int POS_BITS = COORD_BITS + FRAC_BITS;
    localparam int QUO_BITS = FRAC_BITS + 1;
    localparam int STEP_BITS = FRAC_BITS + 2;
    localparam int REM_BITS = COORD_BITS + 1;
    localparam int CNT_BITS = $clog2(FRAC_BITS + 1);
    localparam int S_TDATA_BITS = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;

    localparam logic OP_START = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_X,
        ST_DIV_Y,
        ST_EMIT
    } dda_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

@@ rtl/core/dda_line_rasterizer.sv @@
// Top level of the DDA line rasterizer: input decode, sequencer, position
// accumulators and output register. Depends on dda_pkg and dda_divider.
//
// The s_ channel carries one transaction per command: tuser is the operation
// (start a line or advance one pixel), tdata holds start_x, start_y, end_x and
// end_y. The m_ channel returns one transaction per command: tuser is the
// valid flag, tdata holds pixel_x and pixel_y, and tlast marks the final pixel.
// An advance is accepted and its pixel appears in the output register on the
// next cycle, so advances sustain one pixel per cycle while m_tready is high.
// A start runs the shared bit-serial divider twice, once for x and once for y,
// before the start pixel is shown; s_tready is low meanwhile. A zero-length
// line returns its pixel on the next cycle without a division. When the
// receiver stalls, the result holds in the output register and s_tready
// drops until it is taken. Reset ends any line and leaves the block idle with
// no result pending.
module dda_line_rasterizer (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // Fields from bit 0 up: start_x, start_y, end_x, end_y.
    input  logic [dda_pkg::S_TDATA_BITS-1:0]   s_tdata,
    // Fields from bit 0 up: operation.
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // Fields from bit 0 up: pixel_x, pixel_y, zero padding.
    output logic [dda_pkg::M_TDATA_BITS-1:0]   m_tdata,
    // Fields from bit 0 up: valid_res.
    output logic                               m_tuser,
    output logic                               m_tlast
);
    import dda_pkg::*;

    dda_state_t state_reg, state_next;

    logic [POS_BITS-1:0] pos_x_reg, pos_y_reg, pos_x_next, pos_y_next;
    logic [STEP_BITS-1:0] step_x_reg, step_y_reg;
    logic [COORD_BITS-1:0] steps_left_reg, steps_reg, mag_y_reg;
    logic neg_x_reg, neg_y_reg;

    logic m_valid_reg, m_user_reg, m_last_reg;
    logic [COORD_BITS-1:0] m_pix_x_reg, m_pix_y_reg;

    logic [COORD_BITS-1:0] x0, y0, x1, y1, adx, ady, steps_in;
    logic out_free, in_fire;
    logic div_start;
    logic [COORD_BITS-1:0] div_mag, div_den;
    div_status_t div_status;
    logic [QUO_BITS-1:0] div_quo;

    function automatic logic [STEP_BITS-1:0] signed_step(input logic [QUO_BITS-1:0] q,
                                                         input logic neg);
        logic [STEP_BITS-1:0] ext;
        ext = {1'b0, q};
        return neg ? (~ext + 1'b1) : ext;
    endfunction

    assign x0 = s_tdata[COORD_BITS-1:0];
    assign y0 = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign x1 = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign y1 = s_tdata[4*COORD_BITS-1:3*COORD_BITS];
    assign adx = (x1 >= x0) ? (x1 - x0) : (x0 - x1);
    assign ady = (y1 >= y0) ? (y1 - y0) : (y0 - y1);
    assign steps_in = (adx > ady) ? adx : ady;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign in_fire = s_tvalid && s_tready;

    assign pos_x_next = pos_x_reg
        + {{(POS_BITS-STEP_BITS){step_x_reg[STEP_BITS-1]}}, step_x_reg};
    assign pos_y_next = pos_y_reg
        + {{(POS_BITS-STEP_BITS){step_y_reg[STEP_BITS-1]}}, step_y_reg};

    assign div_mag = (state_reg == ST_IDLE) ? adx : mag_y_reg;
    assign div_den = (state_reg == ST_IDLE) ? steps_in : steps_reg;

    always_comb begin
        state_next = state_reg;
        div_start = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire && (s_tuser == OP_START) && (steps_in != '0)) begin
                    div_start = 1'b1;
                    state_next = ST_DIV_X;
                end
            end
            ST_DIV_X: begin
                if (div_status.done) begin
                    div_start = 1'b1;
                    state_next = ST_DIV_Y;
                end
            end
            ST_DIV_Y: begin
                if (div_status.done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            steps_left_reg <= '0;
        end else if (in_fire) begin
            if (s_tuser == OP_START) begin
                steps_left_reg <= steps_in;
            end else if (steps_left_reg != '0) begin
                steps_left_reg <= steps_left_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            if (s_tuser == OP_START) begin
                pos_x_reg <= {x0, {FRAC_BITS{1'b0}}};
                pos_y_reg <= {y0, {FRAC_BITS{1'b0}}};
                mag_y_reg <= ady;
                steps_reg <= steps_in;
                neg_x_reg <= (x1 < x0);
                neg_y_reg <= (y1 < y0);
            end else if (steps_left_reg != '0) begin
                pos_x_reg <= pos_x_next;
                pos_y_reg <= pos_y_next;
            end
        end
        if ((state_reg == ST_DIV_X) && div_status.done) begin
            step_x_reg <= signed_step(div_quo, neg_x_reg);
        end
        if ((state_reg == ST_DIV_Y) && div_status.done) begin
            step_y_reg <= signed_step(div_quo, neg_y_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((in_fire && ((s_tuser == OP_ADVANCE) || (steps_in == '0)))
                     || ((state_reg == ST_EMIT) && out_free)) begin
            m_valid_reg <= 1'b1;
        end else if (m_valid_reg && m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            if (s_tuser == OP_START) begin
                m_user_reg <= 1'b1;
                m_pix_x_reg <= x0;
                m_pix_y_reg <= y0;
                m_last_reg <= 1'b1;
            end else if (steps_left_reg == '0) begin
                m_user_reg <= 1'b0;
                m_pix_x_reg <= '0;
                m_pix_y_reg <= '0;
                m_last_reg <= 1'b0;
            end else begin
                m_user_reg <= 1'b1;
                m_pix_x_reg <= pos_x_next[POS_BITS-1:FRAC_BITS];
                m_pix_y_reg <= pos_y_next[POS_BITS-1:FRAC_BITS];
                m_last_reg <= (steps_left_reg == COORD_BITS'(1));
            end
        end else if ((state_reg == ST_EMIT) && out_free) begin
            m_user_reg <= 1'b1;
            m_pix_x_reg <= pos_x_reg[POS_BITS-1:FRAC_BITS];
            m_pix_y_reg <= pos_y_reg[POS_BITS-1:FRAC_BITS];
            m_last_reg <= 1'b0;
        end
    end

    dda_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .mag      (div_mag),
        .den      (div_den),
        .status   (div_status),
        .quotient (div_quo)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tuser = m_user_reg;
    assign m_tlast = m_last_reg;
    assign m_tdata = {{(M_TDATA_BITS-2*COORD_BITS){1'b0}}, m_pix_y_reg, m_pix_x_reg};

endmodule

@@ rtl/core/dda_divider.sv @@
// Bit-serial restoring divider for the DDA increments: (mag << FRAC_BITS) / den.
// One quotient bit per cycle, mag no larger than den. Depends on dda_pkg.
module dda_divider (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [dda_pkg::COORD_BITS-1:0]      mag,
    input  logic [dda_pkg::COORD_BITS-1:0]      den,
    output dda_pkg::div_status_t                status,
    output logic [dda_pkg::QUO_BITS-1:0]        quotient
);
    import dda_pkg::*;

    logic [REM_BITS-1:0] rem_reg, rem_next;
    logic [QUO_BITS-1:0] quo_reg, quo_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [COORD_BITS-1:0] den_reg;
    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic [REM_BITS-1:0] trial;
    logic ge;

    always_comb begin
        trial = (cnt_reg == '0) ? rem_reg : {rem_reg[REM_BITS-2:0], 1'b0};
        ge = (trial >= {1'b0, den_reg});
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next = {1'b0, mag};
            quo_next = '0;
            cnt_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? (trial - {1'b0, den_reg}) : trial;
            quo_next = {quo_reg[QUO_BITS-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_BITS'(FRAC_BITS)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
        if (start) begin
            den_reg <= den;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient = quo_reg;

endmodule
